>>> hdl/btop_pkg.sv
// shared constants, types and helpers of the binomial tree option pricer
package btop_pkg;

  localparam int unsigned MaxSteps   = 256;
  localparam int unsigned NodeDepth  = MaxSteps + 1;
  localparam int unsigned AddrW      = $clog2(NodeDepth);
  localparam int unsigned PriceW     = 32;
  localparam int unsigned RatioW     = 31;
  localparam int unsigned TopRatioW  = 48;
  localparam int unsigned RatioFrac  = 30;
  localparam int unsigned ProdW      = PriceW + RatioW;
  localparam int unsigned StepCountW = 9;

  localparam int unsigned ApbAddrW   = 6;
  localparam int unsigned ApbDataW   = 64;
  localparam int unsigned RegIdxW    = ApbAddrW - 3;

  // register indexes on the config port
  localparam logic [RegIdxW-1:0] RegStepCount  = RegIdxW'(0);
  localparam logic [RegIdxW-1:0] RegUpProb     = RegIdxW'(1);
  localparam logic [RegIdxW-1:0] RegDownProb   = RegIdxW'(2);
  localparam logic [RegIdxW-1:0] RegDiscount   = RegIdxW'(3);
  localparam logic [RegIdxW-1:0] RegTopRatio   = RegIdxW'(4);
  localparam logic [RegIdxW-1:0] RegDownSquare = RegIdxW'(5);

  typedef logic [AddrW-1:0] addr_t;

  typedef struct packed {
    logic [StepCountW-1:0] step_count;
    logic [RatioW-1:0]     up_probability;
    logic [RatioW-1:0]     down_probability;
    logic [RatioW-1:0]     step_discount;
    logic [TopRatioW-1:0]  top_ratio;
    logic [RatioW-1:0]     down_squared;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic  capture;
    logic  mul_top;
    logic  mul_leaf;
    logic  leaf_wr;
    logic  leaf_top;
    addr_t wr_addr;
    logic  rd_en;
    logic  rd_node;
    addr_t rd_addr;
    logic  out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic busy;
    logic out_free;
  } status_t;

  // effective number of tree steps: zero acts as one, capped at the tree size
  function automatic addr_t clamp_steps(logic [StepCountW-1:0] sc);
    int unsigned v;
    v = 32'(sc);
    if (v == 0) v = 1;
    if (v > MaxSteps) v = MaxSteps;
    return AddrW'(v);
  endfunction

endpackage

>>> hdl/btop_datapath.sv
// multipliers, node value memory, node update pipeline and result register
module btop_datapath import btop_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  input  cfg_t              cfg_i,
  input  logic [PriceW-1:0] spot_price_i,
  input  logic [PriceW-1:0] strike_price_i,
  input  logic              is_call_i,
  input  logic              out_stall_i,
  output status_t           status_o,
  output logic              out_valid_o,
  output logic [PriceW-1:0] option_value_o,
  output logic              saturated_o
);

  localparam int unsigned WideW = ProdW + 1;
  localparam logic [WideW-1:0] RoundHalf = WideW'(1) << (RatioFrac - 1);

  typedef struct packed {
    logic              sat;
    logic [PriceW-1:0] val;
  } rs_t;

  function automatic rs_t round_sat(logic [WideW-1:0] v);
    logic [WideW-1:0] t;
    rs_t r;
    t = (v + RoundHalf) >> RatioFrac;
    r.sat = |t[WideW-1:PriceW];
    r.val = r.sat ? '1 : t[PriceW-1:0];
    return r;
  endfunction

  function automatic logic [PriceW-1:0] payoff(logic [PriceW-1:0] leaf,
                                               logic [PriceW-1:0] strike,
                                               logic call);
    logic [PriceW-1:0] p;
    if (call) p = (leaf > strike) ? leaf - strike : '0;
    else      p = (strike > leaf) ? strike - leaf : '0;
    return p;
  endfunction

  logic [PriceW-1:0] spot_q, strike_q;
  logic              call_q;
  logic [PriceW-1:0] leaf_q;
  logic              sat_q, sat_d;

  logic [PriceW-1:0] node_mem_q [NodeDepth];
  logic [PriceW-1:0] rdata_q, prev_q;
  logic              rd_any_q;
  logic              rv_q;
  addr_t             ra_q;

  logic [ProdW-1:0]  prod_a_q, prod_b_q, prod_c_q;
  logic              v1_q, v2_q, v3_q;
  addr_t             a1_q, a2_q, a3_q;
  logic [PriceW-1:0] s_q;

  logic              out_valid_q;
  logic [PriceW-1:0] option_value_q;
  logic              saturated_q;

  logic [PriceW-1:0] mul_a_x, mul_b_x;
  logic [RatioW-1:0] mul_a_y, mul_b_y;
  logic              prod_ld;
  logic [WideW-1:0]  part_w, top_sum;
  rs_t               top_rs, leaf_rs, sum_rs, disc_rs;
  logic              mem_we;
  addr_t             mem_wa;
  logic [PriceW-1:0] mem_wd;

  // operand selection for the two shared multipliers
  always_comb begin
    if (cmd_i.mul_top) begin
      mul_a_x = spot_q;
      mul_a_y = RatioW'(cfg_i.top_ratio[TopRatioW-1:RatioFrac]);
      mul_b_x = spot_q;
      mul_b_y = RatioW'(cfg_i.top_ratio[RatioFrac-1:0]);
    end else if (cmd_i.mul_leaf) begin
      mul_a_x = leaf_q;
      mul_a_y = cfg_i.down_squared;
      mul_b_x = rdata_q;
      mul_b_y = cfg_i.down_probability;
    end else begin
      mul_a_x = prev_q;
      mul_a_y = cfg_i.up_probability;
      mul_b_x = rdata_q;
      mul_b_y = cfg_i.down_probability;
    end
  end

  assign prod_ld = cmd_i.mul_top | cmd_i.mul_leaf | rv_q;

  // top leaf: whole part plus rounded fractional part
  always_comb begin
    part_w     = ({1'b0, prod_b_q} + RoundHalf) >> RatioFrac;
    top_sum    = {1'b0, prod_a_q} + part_w;
    top_rs.sat = |top_sum[WideW-1:PriceW];
    top_rs.val = top_rs.sat ? '1 : top_sum[PriceW-1:0];
  end

  assign leaf_rs = cmd_i.leaf_top ? top_rs : round_sat({1'b0, prod_a_q});
  assign sum_rs  = round_sat(WideW'(prod_a_q) + WideW'(prod_b_q));
  assign disc_rs = round_sat({1'b0, prod_c_q});

  always_comb begin
    if (cmd_i.leaf_wr) begin
      mem_we = 1'b1;
      mem_wa = cmd_i.wr_addr;
      mem_wd = payoff(leaf_rs.val, strike_q, call_q);
    end else begin
      mem_we = v3_q;
      mem_wa = a3_q;
      mem_wd = disc_rs.val;
    end
  end

  always_comb begin
    sat_d = sat_q | (cmd_i.leaf_wr & leaf_rs.sat) | (v1_q & sum_rs.sat)
          | (v3_q & disc_rs.sat);
    if (cmd_i.capture) sat_d = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) node_mem_q[mem_wa] <= mem_wd;
    if (cmd_i.rd_en) rdata_q <= node_mem_q[cmd_i.rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      spot_q   <= spot_price_i;
      strike_q <= strike_price_i;
      call_q   <= is_call_i;
    end
    if (cmd_i.leaf_wr) leaf_q <= leaf_rs.val;
    if (cmd_i.rd_en) ra_q <= cmd_i.rd_addr;
    if (rd_any_q) prev_q <= rdata_q;
    if (prod_ld) begin
      prod_a_q <= ProdW'(mul_a_x) * ProdW'(mul_a_y);
      prod_b_q <= ProdW'(mul_b_x) * ProdW'(mul_b_y);
    end
    a1_q     <= ra_q - addr_t'(1);
    s_q      <= sum_rs.val;
    a2_q     <= a1_q;
    prod_c_q <= ProdW'(s_q) * ProdW'(cfg_i.step_discount);
    a3_q     <= a2_q;
    if (cmd_i.out_load) begin
      option_value_q <= rdata_q;
      saturated_q    <= sat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_any_q    <= 1'b0;
      rv_q        <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_any_q <= cmd_i.rd_en;
      rv_q     <= cmd_i.rd_en & cmd_i.rd_node;
      v1_q     <= rv_q;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      sat_q    <= sat_d;
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign status_o.busy     = rv_q | v1_q | v2_q | v3_q;
  assign status_o.out_free = ~out_valid_q | ~out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign option_value_o = option_value_q;
  assign saturated_o    = saturated_q;

endmodule

>>> hdl/btop_ctrl.sv
// sequencer for leaf generation, backward induction and result hand-off
module btop_ctrl import btop_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [8:0] {
    StIdle    = 9'b000000001,
    StTop     = 9'b000000010,
    StTopWr   = 9'b000000100,
    StLeafMul = 9'b000001000,
    StLeafWr  = 9'b000010000,
    StNode    = 9'b000100000,
    StDrain   = 9'b001000000,
    StFetch   = 9'b010000000,
    StLoad    = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  addr_t  idx_q, idx_d;
  addr_t  lvl_q, lvl_d;
  addr_t  steps;

  assign steps      = clamp_steps(cfg_i.step_count);
  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    lvl_d   = lvl_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StTop;
        end
      end
      StTop: begin
        cmd_o.mul_top = 1'b1;
        state_d       = StTopWr;
      end
      StTopWr: begin
        cmd_o.leaf_wr  = 1'b1;
        cmd_o.leaf_top = 1'b1;
        cmd_o.wr_addr  = '0;
        idx_d          = addr_t'(1);
        state_d        = StLeafMul;
      end
      StLeafMul: begin
        cmd_o.mul_leaf = 1'b1;
        state_d        = StLeafWr;
      end
      StLeafWr: begin
        cmd_o.leaf_wr = 1'b1;
        cmd_o.wr_addr = idx_q;
        if (idx_q == steps) begin
          lvl_d   = steps;
          idx_d   = '0;
          state_d = StNode;
        end else begin
          idx_d   = idx_q + addr_t'(1);
          state_d = StLeafMul;
        end
      end
      StNode: begin
        // first read of a level only primes the upper operand
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = idx_q;
        cmd_o.rd_node = (idx_q != '0);
        if (idx_q == lvl_q) state_d = StDrain;
        else idx_d = idx_q + addr_t'(1);
      end
      StDrain: begin
        if (!status_i.busy) begin
          if (lvl_q == addr_t'(1)) begin
            state_d = StFetch;
          end else begin
            lvl_d   = lvl_q - addr_t'(1);
            idx_d   = '0;
            state_d = StNode;
          end
        end
      end
      StFetch: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = '0;
        state_d       = StLoad;
      end
      StLoad: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q   <= '0;
      lvl_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      lvl_q   <= lvl_d;
    end
  end

endmodule

>>> hdl/binomial_tree_option_pricer_unit.sv
// top level of the binomial tree option pricer: config registers and core
//
// usage
// - input channel carries one item: spot price, strike price and call/put flag;
//   an item is taken when in_valid_i is high and in_stall_o is low
// - output channel returns one item per input: option value and saturation flag,
//   taken when out_valid_o is high and out_stall_i is low
// - registers are written over the apb port at byte address 8*index while idle
// - one item at a time; the time from acceptance to out_valid_o grows with the
//   n effective steps and comes from the single read port of the node memory,
//   one node update per cycle, plus a drain of the node pipeline between tree
//   levels and a multiply state and a write state per leaf
// - the next item is accepted as soon as the result sits in the output
//   register, even while the receiver stalls it
// - a stalled result holds its value; the block waits before loading the
//   next result until the output register frees up
// - reset clears the control state and loads the register defaults;
//   the node memory needs no clearing, every entry is written before use
module binomial_tree_option_pricer_unit import btop_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // apb config port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  // input item channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [PriceW-1:0]   spot_price_i,
  input  logic [PriceW-1:0]   strike_price_i,
  input  logic                is_call_i,
  // result item channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [PriceW-1:0]   option_value_o,
  output logic                saturated_o
);

  // register defaults: one step, even odds, no discount, unit ratios
  localparam logic [StepCountW-1:0] StepCountRst = StepCountW'(1);
  localparam logic [RatioW-1:0]     HalfRst      = RatioW'(1) << (RatioFrac - 1);
  localparam logic [RatioW-1:0]     OneRst       = RatioW'(1) << RatioFrac;
  localparam logic [TopRatioW-1:0]  TopOneRst    = TopRatioW'(1) << RatioFrac;

  cfg_t               cfg_q;
  logic               cfg_wr;
  logic [RegIdxW-1:0] reg_idx;
  cmd_t               cmd;
  status_t            status;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ApbAddrW-1:3];
  assign cfg_wr  = psel & penable & pwrite & pready;

  // register file, written in the apb access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_count       <= StepCountRst;
      cfg_q.up_probability   <= HalfRst;
      cfg_q.down_probability <= HalfRst;
      cfg_q.step_discount    <= OneRst;
      cfg_q.top_ratio        <= TopOneRst;
      cfg_q.down_squared     <= OneRst;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegStepCount:  cfg_q.step_count       <= pwdata[StepCountW-1:0];
        RegUpProb:     cfg_q.up_probability   <= pwdata[RatioW-1:0];
        RegDownProb:   cfg_q.down_probability <= pwdata[RatioW-1:0];
        RegDiscount:   cfg_q.step_discount    <= pwdata[RatioW-1:0];
        RegTopRatio:   cfg_q.top_ratio        <= pwdata[TopRatioW-1:0];
        RegDownSquare: cfg_q.down_squared     <= pwdata[RatioW-1:0];
        default: ;
      endcase
    end
  end

  // readback
  always_comb begin
    unique case (reg_idx)
      RegStepCount:  prdata = ApbDataW'(cfg_q.step_count);
      RegUpProb:     prdata = ApbDataW'(cfg_q.up_probability);
      RegDownProb:   prdata = ApbDataW'(cfg_q.down_probability);
      RegDiscount:   prdata = ApbDataW'(cfg_q.step_discount);
      RegTopRatio:   prdata = ApbDataW'(cfg_q.top_ratio);
      RegDownSquare: prdata = ApbDataW'(cfg_q.down_squared);
      default:       prdata = '0;
    endcase
  end

  // sequencer: leaves, then one tree level at a time, then the root
  btop_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // arithmetic, node memory and output register
  btop_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_i          (cfg_q),
    .spot_price_i   (spot_price_i),
    .strike_price_i (strike_price_i),
    .is_call_i      (is_call_i),
    .out_stall_i    (out_stall_i),
    .status_o       (status),
    .out_valid_o    (out_valid_o),
    .option_value_o (option_value_o),
    .saturated_o    (saturated_o)
  );

  // an accepted item keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken but block not busy");

  // leaf writes share the memory write port with the node pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.leaf_wr |-> !status.busy)
    else $error("leaf write while node pipeline active");

  // a new result shows up only after a load command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.out_load))
    else $error("result valid without load");

  // a level start or the root fetch waits for the node pipeline to empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_en && !cmd.rd_node |-> !status.busy)
    else $error("root read during node update");

endmodule

>>> test/binomial_tree_option_pricer_unit_test.sv
// testbench of the binomial tree option pricer: directed and random items checked against a tree predictor
module binomial_tree_option_pricer_unit_test import btop_pkg::*; ();

  localparam int CycleLimit = 1_000_000;
  localparam int HoldOffCycles = 2000;
  localparam logic [63:0] RoundHalf = 64'd1 << (RatioFrac - 1);
  localparam logic [63:0] RatioOne = 64'd1 << RatioFrac;

  // a plausible tree at 256 steps: up factor 1.001, p about 0.52
  localparam logic [63:0] LongTop = 64'd1386827000;
  localparam logic [63:0] LongDownSq = 64'd1071597562;
  localparam logic [63:0] LongUp = 64'd558345748;
  localparam logic [63:0] LongDown = 64'd515396076;
  localparam logic [63:0] LongDisc = 64'd1073634450;

  typedef struct packed {
    logic [PriceW-1:0] value;
    logic              sat;
  } option_quote_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ApbAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  wire  [ApbDataW-1:0] prdata;
  wire                 pready;
  logic                in_valid_i = 1'b0;
  wire                 in_stall_o;
  logic [PriceW-1:0]   spot_price_i = '0;
  logic [PriceW-1:0]   strike_price_i = '0;
  logic                is_call_i = 1'b0;
  wire                 out_valid_o;
  logic                out_stall_i = 1'b0;
  wire  [PriceW-1:0]   option_value_o;
  wire                 saturated_o;

  // register copy used by the predictor
  cfg_t tree_cfg;
  // quotes of accepted items, oldest first
  option_quote_t expected_prices[$];
  int failures = 0;
  // no random idling on either side while set
  logic steady_flow = 1'b0;
  // receiver holds off completely while set
  logic hold_results = 1'b0;

  binomial_tree_option_pricer_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .spot_price_i   (spot_price_i),
    .strike_price_i (strike_price_i),
    .is_call_i      (is_call_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .option_value_o (option_value_o),
    .saturated_o    (saturated_o)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  // saturate to 32 bits, flag in the top bit
  function automatic logic [32:0] clip_price(logic [63:0] v);
    if (v > 64'hFFFF_FFFF) return {1'b1, 32'hFFFF_FFFF};
    return {1'b0, v[31:0]};
  endfunction

  // price times Q1.30 ratio, rounded to nearest with ties up
  function automatic logic [63:0] scale_ratio(logic [PriceW-1:0] price, logic [RatioW-1:0] ratio);
    return (64'(price) * 64'(ratio) + RoundHalf) >> RatioFrac;
  endfunction

  function automatic option_quote_t price_on_tree(logic [PriceW-1:0] spot,
                                                   logic [PriceW-1:0] strike, logic call);
    logic [PriceW-1:0] nodes [0:MaxSteps];
    logic [PriceW-1:0] leaf;
    logic [32:0]       clipped;
    logic [63:0]       acc;
    int unsigned       steps;
    option_quote_t     quote;
    quote.sat = 1'b0;
    steps = 32'(tree_cfg.step_count);
    if (steps == 0) steps = 1;
    if (steps > MaxSteps) steps = MaxSteps;
    // top leaf, integer and fraction part of the ratio taken apart
    acc = 64'(spot) * 64'(tree_cfg.top_ratio >> RatioFrac)
        + ((64'(spot) * 64'(tree_cfg.top_ratio[RatioFrac-1:0]) + RoundHalf) >> RatioFrac);
    clipped = clip_price(acc);
    leaf = clipped[31:0];
    quote.sat |= clipped[32];
    for (int i = 0; i <= int'(steps); i++) begin
      if (i > 0) begin
        clipped = clip_price(scale_ratio(leaf, tree_cfg.down_squared));
        leaf = clipped[31:0];
        quote.sat |= clipped[32];
      end
      if (call) nodes[i] = (leaf > strike) ? leaf - strike : '0;
      else nodes[i] = (strike > leaf) ? strike - leaf : '0;
    end
    // backward induction, one level per pass
    for (int lvl = int'(steps); lvl > 0; lvl--) begin
      for (int j = 0; j < lvl; j++) begin
        acc = 64'(nodes[j]) * 64'(tree_cfg.up_probability)
            + 64'(nodes[j+1]) * 64'(tree_cfg.down_probability);
        clipped = clip_price((acc + RoundHalf) >> RatioFrac);
        quote.sat |= clipped[32];
        clipped = clip_price(scale_ratio(clipped[31:0], tree_cfg.step_discount));
        quote.sat |= clipped[32];
        nodes[j] = clipped[31:0];
      end
    end
    quote.value = nodes[0];
    return quote;
  endfunction

  // ---------------------------------------------------------------- config port

  // setup then access; leaves psel high so back-to-back writes need no release
  task automatic write_register(logic [RegIdxW-1:0] idx, logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      RegStepCount:  tree_cfg.step_count = value[StepCountW-1:0];
      RegUpProb:     tree_cfg.up_probability = value[RatioW-1:0];
      RegDownProb:   tree_cfg.down_probability = value[RatioW-1:0];
      RegDiscount:   tree_cfg.step_discount = value[RatioW-1:0];
      RegTopRatio:   tree_cfg.top_ratio = value[TopRatioW-1:0];
      RegDownSquare: tree_cfg.down_squared = value[RatioW-1:0];
      default: ;
    endcase
  endtask

  task automatic load_tree_config(logic [63:0] steps, logic [63:0] up, logic [63:0] down,
                                  logic [63:0] disc, logic [63:0] top, logic [63:0] dsq);
    write_register(RegStepCount, steps);
    write_register(RegUpProb, up);
    write_register(RegDownProb, down);
    write_register(RegDiscount, disc);
    write_register(RegTopRatio, top);
    write_register(RegDownSquare, dsq);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // mostly a sane tree with small step counts, now and then raw noise
  task automatic load_random_tree();
    logic [63:0] up;
    if ($urandom_range(3) == 0) begin
      load_tree_config(64'($urandom_range(12)), {$urandom, $urandom}, {$urandom, $urandom},
                       {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
    end else begin
      up = 64'($urandom_range(1 << 30));
      load_tree_config(64'(($urandom_range(8) == 0) ? $urandom_range(24, 11)
                                                    : $urandom_range(10, 1)),
                       up, RatioOne - up, RatioOne - 64'($urandom_range(1 << 24)),
                       RatioOne + 64'($urandom_range(1 << 30)),
                       RatioOne - 64'($urandom_range(1 << 27)));
    end
  endtask

  // ---------------------------------------------------------------- item channel

  task automatic send_item(logic [PriceW-1:0] spot, logic [PriceW-1:0] strike, logic call);
    if (!steady_flow) begin
      while ($urandom_range(99) < 37) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    spot_price_i <= spot;
    strike_price_i <= strike;
    is_call_i <= call;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_prices.push_back(price_on_tree(spot, strike, call));
  endtask

  // strike near spot most of the time, any bit pattern otherwise
  task automatic send_random_item();
    logic [PriceW-1:0] spot;
    logic [PriceW-1:0] strike;
    logic [PriceW-1:0] offs;
    if ($urandom_range(3) == 0) begin
      spot = $urandom;
      strike = $urandom;
    end else begin
      spot = $urandom_range(32'h1000_0000, 32'h0001_0000);
      offs = $urandom_range(spot >> 2);
      strike = $urandom_range(1) ? spot + offs : spot - offs;
    end
    send_item(spot, strike, 1'($urandom_range(1)));
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (expected_prices.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- result check

  always @(posedge clk_i) begin : result_check
    option_quote_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_prices.size() == 0) begin
        $display("%0t: result with nothing expected, option_value %h saturated %b",
                 $time, option_value_o, saturated_o);
        failures++;
      end else begin
        want = expected_prices.pop_front();
        if (option_value_o !== want.value) begin
          $display("%0t: option_value expected %h got %h", $time, want.value, option_value_o);
          failures++;
        end
        if (saturated_o !== want.sat) begin
          $display("%0t: saturated expected %b got %b", $time, want.sat, saturated_o);
          failures++;
        end
      end
    end
    out_stall_i <= hold_results || (!steady_flow && $urandom_range(99) < 37);
  end

  // ---------------------------------------------------------------- tests

  // register defaults: one step, even odds, no discount, flat leaves
  task automatic test_reset_defaults();
    send_item('0, '0, 1'b1);
    send_item('1, '0, 1'b1);
    send_item('0, '1, 1'b0);
    send_item('1, '1, 1'b1);
    send_item('1, '1, 1'b0);
    send_item(32'h0064_0000, 32'h0060_0000, 1'b1);
    send_item(32'h0064_0000, 32'h0060_0000, 1'b0);
    wait_for_results();
  endtask

  // zero steps acts as one, 256 is the full tree, all ones is capped to it
  task automatic test_step_extremes();
    load_tree_config(64'd0, LongUp, LongDown, LongDisc, RatioOne + (64'd1 << 28), LongDownSq);
    send_item(32'h0064_0000, 32'h0064_0000, 1'b1);
    send_item(32'h0064_0000, 32'h0070_0000, 1'b0);
    wait_for_results();
    load_tree_config(64'(MaxSteps), LongUp, LongDown, LongDisc, LongTop, LongDownSq);
    send_item(32'h0064_0000, 32'h0068_0000, 1'b1);
    wait_for_results();
    load_tree_config('1, LongUp, LongDown, LongDisc, LongTop, LongDownSq);
    send_item(32'h0064_0000, 32'h0060_0000, 1'b0);
    wait_for_results();
  endtask

  task automatic test_ratio_extremes();
    // every ratio at its widest: leaves and sums saturate
    load_tree_config(64'd3, '1, '1, '1, '1, '1);
    send_item(32'h0001_0000, 32'h0000_8000, 1'b1);
    send_item('1, '1, 1'b0);
    send_item('0, 32'h0001_0000, 1'b1);
    wait_for_results();
    // zero probabilities, discount and leaf step
    load_tree_config(64'd2, 64'd0, 64'd0, 64'd0, RatioOne, 64'd0);
    send_item(32'h0064_0000, 32'h0010_0000, 1'b1);
    send_item(32'h0064_0000, 32'h0080_0000, 1'b0);
    wait_for_results();
    // odds that sum past one
    load_tree_config(64'd5, 64'd751619277, 64'd644245094, LongDisc, RatioOne + (64'd1 << 27),
                     RatioOne - (64'd1 << 24));
    send_item(32'h0064_0000, 32'h0064_0000, 1'b1);
    send_item(32'h0064_0000, 32'h0064_0000, 1'b0);
    wait_for_results();
  endtask

  task automatic test_random_trees();
    repeat (7) begin
      load_random_tree();
      repeat (10) send_random_item();
      wait_for_results();
    end
  endtask

  // receiver stops long enough for the output register and the core to fill
  task automatic test_back_pressure();
    load_random_tree();
    fork
      begin
        hold_results <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_results <= 1'b0;
      end
      repeat (6) send_random_item();
    join
    wait_for_results();
  endtask

  task automatic test_steady_flow();
    steady_flow <= 1'b1;
    load_random_tree();
    repeat (10) send_random_item();
    wait_for_results();
    steady_flow <= 1'b0;
  endtask

  // ---------------------------------------------------------------- run

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    tree_cfg.step_count = StepCountW'(1);
    tree_cfg.up_probability = RatioW'(RoundHalf);
    tree_cfg.down_probability = RatioW'(RoundHalf);
    tree_cfg.step_discount = RatioW'(RatioOne);
    tree_cfg.top_ratio = TopRatioW'(RatioOne);
    tree_cfg.down_squared = RatioW'(RatioOne);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_step_extremes();
    test_ratio_extremes();
    test_random_trees();
    test_back_pressure();
    test_steady_flow();
    wait_for_results();
    // catch stray results after the last one
    repeat (200) @(posedge clk_i);
    if (failures == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
